// ===== hdl/nvp_pkg.sv =====
package nvp_pkg;

    // Size of the data area in bytes and the name length at which a name is rejected as too long.
    localparam int unsigned AREA_SIZE  = 4096;
    localparam int unsigned NAME_LIMIT = 32;

    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_NULL   = 8'h00;

    typedef enum logic [1:0] {
        PH_DONE  = 2'd0,
        PH_NAME  = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_PROP       = 3'd0,
        ST_FREE       = 3'd1,
        ST_AREA_END   = 3'd2,
        ST_NAME_LONG  = 3'd3,
        ST_NO_EQUALS  = 3'd4,
        ST_EMPTY_NAME = 3'd5,
        ST_EARLY_NULL = 3'd6,
        ST_OVERRUN    = 3'd7
    } status_t;

    // One result beat as held in the output stage.
    typedef struct packed {
        status_t     status;
        logic [11:0] name_start;
        logic [4:0]  name_length;
        logic [11:0] value_start;
        logic [11:0] value_length;
        logic [12:0] used_length;
    } result_t;

endpackage

// ===== hdl/nvram_name_value_parser.sv =====
// A result beat goes to the result register, or to the skid register while m_tready is low.
// Throughput: one byte per cycle while the skid register is empty; one parse pass per byte.
// Output: a result register plus one skid register, so bytes keep flowing while a result waits.
// Reset: aresetn is synchronous and active low; it empties the output stage and leaves the
// parser done, so nothing is parsed until a byte with the restart flag arrives.
module nvram_name_value_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] restart

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [11:0] name_start, [16:12] name_length,
                                   // [28:17] value_start, [40:29] value_length,
                                   // [53:41] used_length, [55:54] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int unsigned AREA_LIMIT = nvp_pkg::AREA_SIZE;
    localparam int unsigned NAME_MAX   = nvp_pkg::NAME_LIMIT;

    // Parser state.
    nvp_pkg::phase_t phase_reg, phase_next;
    logic [12:0] position_reg, position_next;
    logic [5:0]  name_count_reg, name_count_next;
    logic [11:0] name_offset_reg, name_offset_next;
    logic [11:0] value_offset_reg, value_offset_next;
    logic [12:0] value_count_reg, value_count_next;
    logic [12:0] used_count_reg, used_count_next;

    // Output stage: main register and skid register.
    nvp_pkg::result_t out_data_reg, skid_data_reg;
    logic out_valid_reg, skid_valid_reg;

    logic             accept;
    logic             active;
    logic             has_result;
    nvp_pkg::result_t result;

    // State as seen by this byte: a restart replaces the stored state with the reset
    // values and opens a name at offset zero.
    nvp_pkg::phase_t eff_phase;
    logic [12:0] eff_pos;
    logic [5:0]  eff_name_count;
    logic [11:0] eff_name_offset;
    logic [11:0] eff_value_offset;
    logic [12:0] eff_value_count;
    logic [12:0] eff_used;

    logic [13:0] pos_inc;
    logic [5:0]  name_count_inc;
    logic [11:0] cur_name_offset;
    logic        at_end;
    logic        name_full;
    logic        is_equals;
    logic        is_null;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign eff_phase        = s_tuser ? nvp_pkg::PH_NAME : phase_reg;
    assign eff_pos          = s_tuser ? 13'd0 : position_reg;
    assign eff_name_count   = s_tuser ? 6'd0  : name_count_reg;
    assign eff_name_offset  = s_tuser ? 12'd0 : name_offset_reg;
    assign eff_value_offset = s_tuser ? 12'd0 : value_offset_reg;
    assign eff_value_count  = s_tuser ? 13'd0 : value_count_reg;
    assign eff_used         = s_tuser ? 13'd0 : used_count_reg;

    assign active = accept && (eff_phase != nvp_pkg::PH_DONE);

    // Offset just past this byte, kept one bit wider so the area-end compare cannot wrap.
    assign pos_inc         = {1'b0, eff_pos} + 14'd1;
    assign at_end          = pos_inc >= 14'(AREA_LIMIT);
    assign name_count_inc  = eff_name_count + 6'd1;
    assign name_full       = name_count_inc >= 6'(NAME_MAX);
    // The first name byte fixes where the name starts.
    assign cur_name_offset = (eff_name_count == 6'd0) ? eff_pos[11:0] : eff_name_offset;
    assign is_equals       = s_tdata == nvp_pkg::CHAR_EQUALS;
    assign is_null         = s_tdata == nvp_pkg::CHAR_NULL;

    // Next state of the parser.
    always_comb begin
        phase_next        = phase_reg;
        position_next     = position_reg;
        name_count_next   = name_count_reg;
        name_offset_next  = name_offset_reg;
        value_offset_next = value_offset_reg;
        value_count_next  = value_count_reg;
        used_count_next   = used_count_reg;
        if (active) begin
            phase_next        = eff_phase;
            position_next     = pos_inc[12:0];
            name_count_next   = eff_name_count;
            name_offset_next  = eff_name_offset;
            value_offset_next = eff_value_offset;
            value_count_next  = eff_value_count;
            used_count_next   = eff_used;
            unique case (eff_phase)
                nvp_pkg::PH_NAME: begin
                    name_offset_next = cur_name_offset;
                    if (is_equals) begin
                        if ((eff_name_count == 6'd0) || at_end) begin
                            phase_next = nvp_pkg::PH_DONE;
                        end else begin
                            phase_next        = nvp_pkg::PH_VALUE;
                            value_offset_next = pos_inc[11:0];
                            value_count_next  = 13'd0;
                        end
                    end else if (is_null) begin
                        phase_next = nvp_pkg::PH_DONE;
                    end else begin
                        name_count_next = name_count_inc;
                        if (name_full || at_end) begin
                            phase_next = nvp_pkg::PH_DONE;
                        end
                    end
                end
                nvp_pkg::PH_VALUE: begin
                    if (is_null) begin
                        used_count_next  = pos_inc[12:0];
                        name_count_next  = 6'd0;
                        value_count_next = 13'd0;
                        phase_next       = at_end ? nvp_pkg::PH_DONE : nvp_pkg::PH_NAME;
                    end else begin
                        value_count_next = eff_value_count + 13'd1;
                        if (at_end) begin
                            phase_next = nvp_pkg::PH_DONE;
                        end
                    end
                end
                default: begin
                    phase_next = nvp_pkg::PH_DONE;
                end
            endcase
        end
    end

    // Result of this byte, if it causes one. Status beats carry only the used length.
    always_comb begin
        has_result          = 1'b0;
        result              = '0;
        result.status       = nvp_pkg::ST_PROP;
        result.used_length  = eff_used;
        if (active) begin
            unique case (eff_phase)
                nvp_pkg::PH_NAME: begin
                    if (is_equals) begin
                        if (eff_name_count == 6'd0) begin
                            has_result    = 1'b1;
                            result.status = nvp_pkg::ST_EMPTY_NAME;
                        end else if (at_end) begin
                            has_result    = 1'b1;
                            result.status = nvp_pkg::ST_OVERRUN;
                        end
                    end else if (is_null) begin
                        has_result    = 1'b1;
                        result.status = (eff_name_count == 6'd0) ? nvp_pkg::ST_FREE
                                                                 : nvp_pkg::ST_EARLY_NULL;
                    end else if (name_full) begin
                        // The name limit wins over the area end on the same byte.
                        has_result    = 1'b1;
                        result.status = nvp_pkg::ST_NAME_LONG;
                    end else if (at_end) begin
                        has_result    = 1'b1;
                        result.status = nvp_pkg::ST_AREA_END;
                    end
                end
                nvp_pkg::PH_VALUE: begin
                    if (is_null) begin
                        has_result          = 1'b1;
                        result.status       = nvp_pkg::ST_PROP;
                        result.name_start   = eff_name_offset;
                        result.name_length  = eff_name_count[4:0];
                        result.value_start  = eff_value_offset;
                        result.value_length = eff_value_count[11:0];
                        result.used_length  = pos_inc[12:0];
                    end else if (at_end) begin
                        has_result    = 1'b1;
                        result.status = nvp_pkg::ST_OVERRUN;
                    end
                end
                default: begin
                    has_result = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= nvp_pkg::PH_DONE;
            position_reg     <= '0;
            name_count_reg   <= '0;
            name_offset_reg  <= '0;
            value_offset_reg <= '0;
            value_count_reg  <= '0;
            used_count_reg   <= '0;
        end else begin
            phase_reg        <= phase_next;
            position_reg     <= position_next;
            name_count_reg   <= name_count_next;
            name_offset_reg  <= name_offset_next;
            value_offset_reg <= value_offset_next;
            value_count_reg  <= value_count_next;
            used_count_reg   <= used_count_next;
        end
    end

    // Output stage. While the skid register is full the slave side is held off, so a new
    // result only arrives when the skid register is empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (has_result) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg  <= result;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= result;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.status;
    assign m_tdata  = {2'b00,
                       out_data_reg.used_length,
                       out_data_reg.value_length,
                       out_data_reg.value_start,
                       out_data_reg.name_length,
                       out_data_reg.name_start};

endmodule
